// ===== sv/assert_macros.svh =====
// Assertion macros used by the top level of the point transform core.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition a must bring condition c in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");

// Condition a must be followed by condition c after the delay given by n.
`define ASSERT_DELAYED(label, clk, rst_n, a, n, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> ##n (c)) \
		else $error("assertion failed");

`endif

// ===== sv/mpt_pkg.sv =====
// Types and constants of the 4x4 point transform core.
// No dependencies; imported by the lane, merge and top-level modules.
package mpt_pkg;

	localparam int NUM_ROWS = 4;
	localparam int COMP_W   = 16;
	localparam int ROW_W    = NUM_ROWS * COMP_W;
	localparam int PROD_W   = 2 * COMP_W;
	// four products of at most 2^30 in magnitude, plus the rounding half
	localparam int ACC_W    = PROD_W + 3;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW0 = 2'd0,
		REG_ROW1 = 2'd1,
		REG_ROW2 = 2'd2,
		REG_ROW3 = 2'd3
	} cfg_reg_t;

	// identity matrix, Q4.12
	localparam logic [ROW_W-1:0] ROW0_RESET = 64'h0000_0000_0000_1000;
	localparam logic [ROW_W-1:0] ROW1_RESET = 64'h0000_0000_1000_0000;
	localparam logic [ROW_W-1:0] ROW2_RESET = 64'h0000_1000_0000_0000;
	localparam logic [ROW_W-1:0] ROW3_RESET = 64'h1000_0000_0000_0000;

	typedef logic signed [COMP_W-1:0] comp_t;

	typedef struct packed {
		comp_t x;
		comp_t y;
		comp_t z;
		comp_t w;
	} point_t;

	typedef struct packed {
		comp_t val;
		logic  clip;
	} lane_res_t;

endpackage

// ===== sv/matrix4_point_transform_core.sv =====
// Top level of the 4x4 matrix point transform core: row registers,
// four row lanes and the merge stage. Depends on mpt_pkg, mpt_lane,
// mpt_merge and assert_macros.svh.

// Transforms one homogeneous point (in_x..in_w, signed 16-bit) per clock by
// the 4x4 matrix held in row0..row3 coefficient registers (four signed Q4.12
// values per row, column k in bits 16k+15:16k, identity after reset). Each
// output is the exact dot product, rounded by adding one half and shifting
// right by FRAC_BITS (ties go toward plus infinity), then clipped to signed
// 16 bits; saturated flags a clip in any of the four components.
// A point is taken at every clock edge with start high; busy never rises, so
// a new point may follow in every cycle. The result beat appears on
// out_x..out_w and saturated with done high for exactly one cycle, after
// a multiply stage, a sum stage, a round/clip stage in each lane and the
// merge register. The receiver cannot stall the beat. Write coefficients
// through cfg_we/cfg_index/cfg_data only while no point is in flight.
module matrix4_point_transform_core #(
	parameter int FRAC_BITS = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mpt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mpt_pkg::ROW_W-1:0]     cfg_data,
	input  logic                          start,
	output logic                          busy,
	input  mpt_pkg::comp_t                in_x,
	input  mpt_pkg::comp_t                in_y,
	input  mpt_pkg::comp_t                in_z,
	input  mpt_pkg::comp_t                in_w,
	output logic                          done,
	output mpt_pkg::comp_t                out_x,
	output mpt_pkg::comp_t                out_y,
	output mpt_pkg::comp_t                out_z,
	output mpt_pkg::comp_t                out_w,
	output logic                          saturated
);
	import mpt_pkg::*;
	`include "assert_macros.svh"

	logic [ROW_W-1:0] row_q [NUM_ROWS];
	point_t           pt;
	lane_res_t        lane_res [NUM_ROWS];
	logic             accept;
	logic             valid_s1, valid_s2, valid_s3;

	// The pipeline never blocks: every start is a beat.
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// Coefficient registers; reset to identity, write one row per beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0] <= ROW0_RESET;
			row_q[1] <= ROW1_RESET;
			row_q[2] <= ROW2_RESET;
			row_q[3] <= ROW3_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ROW0: row_q[0] <= cfg_data;
				REG_ROW1: row_q[1] <= cfg_data;
				REG_ROW2: row_q[2] <= cfg_data;
				REG_ROW3: row_q[3] <= cfg_data;
			endcase
		end
	end

	// Track each beat through the three lane stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	assign pt.x = in_x;
	assign pt.y = in_y;
	assign pt.z = in_z;
	assign pt.w = in_w;

	// One lane per matrix row; all lanes see the same point.
	for (genvar r = 0; r < NUM_ROWS; r++) begin : g_lane
		mpt_lane #(
			.FRAC_BITS(FRAC_BITS)
		) u_lane (
			.clk  (clk),
			.coefs(row_q[r]),
			.pt   (pt),
			.res  (lane_res[r])
		);
	end

	// Combine lane values and clip flags into the output beat.
	mpt_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (valid_s3),
		.lanes    (lane_res),
		.done     (done),
		.out_x    (out_x),
		.out_y    (out_y),
		.out_z    (out_z),
		.out_w    (out_w),
		.saturated(saturated)
	);

	`ASSERT_DELAYED(a_beat_latency, clk, arst_n, accept, 4, done)
	`ASSERT_IMPLIES(a_done_from_pipe, clk, arst_n, done, $past(valid_s3))
	`ASSERT_IMPLIES(a_sat_only_on_done, clk, arst_n, saturated, done)

endmodule

// ===== sv/mpt_lane.sv =====
// One row lane: four products, sum with rounding half, shift and saturate.
// Depends on mpt_pkg.
module mpt_lane #(
	parameter int FRAC_BITS = 12
) (
	input  logic                      clk,
	input  logic [mpt_pkg::ROW_W-1:0] coefs,
	input  mpt_pkg::point_t           pt,
	output mpt_pkg::lane_res_t        res
);
	import mpt_pkg::*;

	localparam int HALF_I = (1 << FRAC_BITS) >> 1;
	localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(HALF_I);
	localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(32768);

	comp_t                    comp [NUM_ROWS];
	comp_t                    coef [NUM_ROWS];
	logic signed [PROD_W-1:0] prod_s1 [NUM_ROWS];
	logic signed [ACC_W-1:0]  sum_s2;
	logic signed [ACC_W-1:0]  shifted;
	lane_res_t                res_nx;
	lane_res_t                res_s3;

	always_comb begin
		comp[0] = pt.x;
		comp[1] = pt.y;
		comp[2] = pt.z;
		comp[3] = pt.w;
		for (int k = 0; k < NUM_ROWS; k++) begin
			coef[k] = signed'(coefs[COMP_W*k +: COMP_W]);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NUM_ROWS; k++) begin
			prod_s1[k] <= coef[k] * comp[k];
		end
	end

	always_ff @(posedge clk) begin
		sum_s2 <= ACC_W'(prod_s1[0]) + ACC_W'(prod_s1[1])
			+ ACC_W'(prod_s1[2]) + ACC_W'(prod_s1[3]) + HALF;
	end

	// arithmetic shift floors, so ties round toward plus infinity
	assign shifted = sum_s2 >>> FRAC_BITS;

	always_comb begin
		priority if (shifted > SAT_MAX) begin
			res_nx.val  = comp_t'(SAT_MAX);
			res_nx.clip = 1'b1;
		end else if (shifted < SAT_MIN) begin
			res_nx.val  = comp_t'(SAT_MIN);
			res_nx.clip = 1'b1;
		end else begin
			res_nx.val  = comp_t'(shifted);
			res_nx.clip = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		res_s3 <= res_nx;
	end

	assign res = res_s3;

endmodule

// ===== sv/mpt_merge.sv =====
// Merge stage: gather the four lane results into one output beat.
// Depends on mpt_pkg.
module mpt_merge (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid,
	input  mpt_pkg::lane_res_t lanes [mpt_pkg::NUM_ROWS],
	output logic               done,
	output mpt_pkg::comp_t     out_x,
	output mpt_pkg::comp_t     out_y,
	output mpt_pkg::comp_t     out_z,
	output mpt_pkg::comp_t     out_w,
	output logic               saturated
);
	import mpt_pkg::*;

	logic  done_q;
	logic  sat_q;
	comp_t x_q, y_q, z_q, w_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			sat_q  <= 1'b0;
		end else begin
			done_q <= valid;
			sat_q  <= valid & (lanes[0].clip | lanes[1].clip
				| lanes[2].clip | lanes[3].clip);
		end
	end

	always_ff @(posedge clk) begin
		if (valid) begin
			x_q <= lanes[0].val;
			y_q <= lanes[1].val;
			z_q <= lanes[2].val;
			w_q <= lanes[3].val;
		end
	end

	assign done      = done_q;
	assign saturated = sat_q;
	assign out_x     = x_q;
	assign out_y     = y_q;
	assign out_z     = z_q;
	assign out_w     = w_q;

endmodule

// ===== test/matrix4_point_transform_core_test.sv =====
// Self-checking bench for matrix4_point_transform_core: streams points under a series of
// coefficient matrices and checks every result beat against its own fixed-point predictor.
// Depends on mpt_pkg and the RTL of the core; needs no files or arguments.
module matrix4_point_transform_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mpt_pkg::*;

	localparam int CLK_PERIOD    = 10;
	localparam int FRAC_BITS     = 12;
	localparam int RANDOM_POINTS = 1850;
	// pipeline is four deep; settle past the drain so that stray beats show up
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 200000;

	localparam comp_t C_MAX     = 16'sh7FFF;
	localparam comp_t C_MIN     = 16'sh8000;
	localparam comp_t COEF_MAX  = 16'sh7FFF;	// just under +8.0 in Q4.12
	localparam comp_t COEF_MIN  = 16'sh8000;	// -8.0
	localparam comp_t COEF_ZERO = 16'sh0000;

	// one result beat as it leaves the core
	typedef struct packed {
		comp_t x;
		comp_t y;
		comp_t z;
		comp_t w;
		logic  sat;
	} xform_beat_t;

	// flavors of random coefficient matrices
	typedef enum int {
		MIX_SMALL,	// within +-1.0, mostly unclipped results
		MIX_FULL,	// any 16-bit pattern, mostly clipped
		MIX_EXTREME,	// corner coefficients only
		MIX_HALVES	// multiples of 0.5, rounding ties with odd inputs
	} coef_mix_t;

	// Keeps its own copy of the four row registers, predicts each point's
	// transform when the point is taken, and checks beats in order.
	class transform_scoreboard;
		localparam longint OUT_MAX = (longint'(1) <<< (COMP_W - 1)) - 1;
		localparam longint OUT_MIN = -OUT_MAX - 1;

		logic [ROW_W-1:0] matrix_rows [NUM_ROWS];
		xform_beat_t      awaited [$];
		int               mismatches;
		int               points_seen;
		int               beats_checked;
		int               clipped_beats;

		function new();
			matrix_rows[0] = ROW0_RESET;
			matrix_rows[1] = ROW1_RESET;
			matrix_rows[2] = ROW2_RESET;
			matrix_rows[3] = ROW3_RESET;
			mismatches     = 0;
			points_seen    = 0;
			beats_checked  = 0;
			clipped_beats  = 0;
		endfunction

		function void load_row(cfg_reg_t idx, logic [ROW_W-1:0] data);
			matrix_rows[int'(idx)] = data;
		endfunction

		task report_mismatch(string msg);
			$display("[%0t] MISMATCH: %s", $realtime, msg);
			mismatches++;
		endtask

		// exact dot product, add half an LSB, floor-shift, clip to 16 bits
		function comp_t row_product(logic [ROW_W-1:0] row, point_t pt, inout logic clip);
			comp_t  comps [NUM_ROWS];
			longint acc;
			longint half;
			longint rounded;
			int     k;
			comps[0] = pt.x;
			comps[1] = pt.y;
			comps[2] = pt.z;
			comps[3] = pt.w;
			acc = 0;
			for (k = 0; k < NUM_ROWS; k++)
				acc += longint'(comp_t'(row[COMP_W*k +: COMP_W])) * longint'(comps[k]);
			half    = (longint'(1) <<< FRAC_BITS) >>> 1;
			rounded = (acc + half) >>> FRAC_BITS;
			if (rounded > OUT_MAX) begin
				rounded = OUT_MAX;
				clip    = 1'b1;
			end else if (rounded < OUT_MIN) begin
				rounded = OUT_MIN;
				clip    = 1'b1;
			end
			return comp_t'(rounded[COMP_W-1:0]);
		endfunction

		function void note_point(point_t pt);
			xform_beat_t predicted;
			logic        clip;
			clip          = 1'b0;
			predicted.x   = row_product(matrix_rows[0], pt, clip);
			predicted.y   = row_product(matrix_rows[1], pt, clip);
			predicted.z   = row_product(matrix_rows[2], pt, clip);
			predicted.w   = row_product(matrix_rows[3], pt, clip);
			predicted.sat = clip;
			awaited.push_back(predicted);
			points_seen++;
		endfunction

		task compare_field(string field, logic signed [COMP_W-1:0] got,
				logic signed [COMP_W-1:0] want);
			if (got !== want)
				report_mismatch($sformatf("beat %0d %s: got %0d, want %0d",
					beats_checked, field, got, want));
		endtask

		task check_beat(xform_beat_t got);
			xform_beat_t want;
			if (awaited.size() == 0) begin
				report_mismatch($sformatf("beat with nothing pending: %0d %0d %0d %0d sat %0b",
					got.x, got.y, got.z, got.w, got.sat));
				return;
			end
			want = awaited.pop_front();
			beats_checked++;
			if (want.sat)
				clipped_beats++;
			compare_field("out_x", got.x, want.x);
			compare_field("out_y", got.y, want.y);
			compare_field("out_z", got.z, want.z);
			compare_field("out_w", got.w, want.w);
			compare_field("saturated", {{(COMP_W-1){1'b0}}, got.sat},
				{{(COMP_W-1){1'b0}}, want.sat});
		endtask
	endclass

	// every input known from time zero
	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [ROW_W-1:0] cfg_data  = '0;
	logic             start     = 1'b0;
	logic             busy;
	comp_t            in_x      = '0;
	comp_t            in_y      = '0;
	comp_t            in_z      = '0;
	comp_t            in_w      = '0;
	logic             done;
	comp_t            out_x;
	comp_t            out_y;
	comp_t            out_z;
	comp_t            out_w;
	logic             saturated;

	int cycle_count    = 0;
	int settings_used  = 1;	// identity out of reset counts as the first
	int random_sent    = 0;

	transform_scoreboard sb = new();

	matrix4_point_transform_core #(
		.FRAC_BITS(FRAC_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.start(start),
		.busy(busy),
		.in_x(in_x),
		.in_y(in_y),
		.in_z(in_z),
		.in_w(in_w),
		.done(done),
		.out_x(out_x),
		.out_y(out_y),
		.out_z(out_z),
		.out_w(out_w),
		.saturated(saturated)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Watchdog: give up far beyond the slowest legal run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d beats pending", cycle_count,
				sb.awaited.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Monitor: sample the pre-edge values of every port at each rising edge.
	// Results are checked, register writes mirrored, and accepted points
	// predicted against the matrix that the core holds at that edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_beat(xform_beat_t'{out_x, out_y, out_z, out_w, saturated});
			if (cfg_we)
				sb.load_row(cfg_reg_t'(cfg_index), cfg_data);
			if (start && !busy)
				sb.note_point(point_t'{in_x, in_y, in_z, in_w});
		end
	end

	// Present one point and hold it until an edge takes it. Every driving task
	// ends on a clock edge, so no signal sees two assignments in one step.
	task automatic send_point(point_t pt);
		start <= 1'b1;
		in_x  <= pt.x;
		in_y  <= pt.y;
		in_z  <= pt.z;
		in_w  <= pt.w;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Drop start for a number of cycles; scramble the idle lanes meanwhile.
	task automatic idle_for(int cycles);
		start <= 1'b0;
		in_x  <= comp_t'($urandom);
		in_y  <= comp_t'($urandom);
		in_z  <= comp_t'($urandom);
		in_w  <= comp_t'($urandom);
		repeat (cycles) @(posedge clk);
	endtask

	// Hold off the sender until every predicted beat has come back.
	task automatic wait_drain();
		start <= 1'b0;
		do
			@(posedge clk);
		while (sb.awaited.size() != 0);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [ROW_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	// Load a whole matrix; the core must be empty first, and every point
	// yields a beat, so an empty queue means nothing is still in flight.
	task automatic write_matrix(logic [ROW_W-1:0] r0, logic [ROW_W-1:0] r1,
			logic [ROW_W-1:0] r2, logic [ROW_W-1:0] r3);
		wait_drain();
		write_reg(REG_ROW0, r0);
		write_reg(REG_ROW1, r1);
		write_reg(REG_ROW2, r2);
		write_reg(REG_ROW3, r3);
		settings_used++;
	endtask

	function automatic comp_t random_coef(coef_mix_t mix);
		comp_t c;
		case (mix)
			MIX_SMALL:   c = comp_t'(int'($urandom_range(0, 8192)) - 4096);
			MIX_FULL:    c = comp_t'($urandom);
			MIX_HALVES:  c = comp_t'((int'($urandom_range(0, 16)) - 8) * 2048);
			default: begin
				case ($urandom_range(0, 5))
					0:       c = COEF_MAX;
					1:       c = COEF_MIN;
					2:       c = COEF_ZERO;
					3:       c = 16'shFFFF;
					4:       c = 16'sh1000;
					default: c = 16'shF000;
				endcase
			end
		endcase
		return c;
	endfunction

	function automatic logic [ROW_W-1:0] random_row(coef_mix_t mix);
		logic [ROW_W-1:0] row;
		int               k;
		for (k = 0; k < NUM_ROWS; k++)
			row[COMP_W*k +: COMP_W] = random_coef(mix);
		return row;
	endfunction

	// Full-range components four times in ten, with small values, corners and
	// tiny odd values mixed in so that rounding ties and unclipped sums occur.
	function automatic comp_t random_comp();
		comp_t c;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: c = comp_t'($urandom);
			4, 5, 6:    c = comp_t'(int'($urandom_range(0, 4096)) - 2048);
			7: begin
				case ($urandom_range(0, 4))
					0:       c = C_MAX;
					1:       c = C_MIN;
					2:       c = '0;
					3:       c = -16'sd1;
					default: c = 16'sd1;
				endcase
			end
			default:    c = comp_t'(int'($urandom_range(0, 14)) - 7);
		endcase
		return c;
	endfunction

	function automatic point_t random_point();
		return point_t'{random_comp(), random_comp(), random_comp(), random_comp()};
	endfunction

	// Stream random points in bursts: sometimes back to back, sometimes with
	// a short gap, now and then a full drain of the pipeline.
	task automatic run_traffic(int count);
		int left;
		int burst;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 24);
			if (burst > left)
				burst = left;
			repeat (burst) send_point(random_point());
			left        -= burst;
			random_sent += burst;
			case ($urandom_range(0, 9))
				0, 1, 2: ;	// no gap: the next burst follows at once
				3:       wait_drain();
				default: idle_for($urandom_range(1, 6));
			endcase
		end
	endtask

	initial begin
		int        phase;
		int        batch;
		coef_mix_t mix;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Identity out of reset: points must come back unchanged.
		send_point(point_t'{16'sd0, 16'sd0, 16'sd0, 16'sd0});
		send_point(point_t'{C_MAX, C_MAX, C_MAX, C_MAX});
		send_point(point_t'{C_MIN, C_MIN, C_MIN, C_MIN});
		send_point(point_t'{16'sd1, -16'sd1, C_MAX, C_MIN});
		send_point(point_t'{16'sh5555, 16'shAAAA, 16'sh00FF, 16'shFF00});

		// Largest coefficients: clip high, clip low, and 32767/4096 rounding up to 8.
		write_matrix({4{COEF_MAX}}, {4{COEF_MAX}}, {4{COEF_MAX}}, {4{COEF_MAX}});
		send_point(point_t'{C_MAX, C_MAX, C_MAX, C_MAX});
		send_point(point_t'{C_MIN, C_MIN, C_MIN, C_MIN});
		send_point(point_t'{16'sd1, 16'sd0, 16'sd0, 16'sd0});

		// Most negative coefficients: sign flips into both clip directions.
		write_matrix({4{COEF_MIN}}, {4{COEF_MIN}}, {4{COEF_MIN}}, {4{COEF_MIN}});
		send_point(point_t'{C_MAX, C_MAX, C_MAX, C_MAX});
		send_point(point_t'{C_MIN, C_MIN, C_MIN, C_MIN});
		send_point(point_t'{16'sd1, 16'sd1, 16'sd1, 16'sd1});

		// Half on the diagonal: odd inputs land on ties, which go toward +inf.
		write_matrix(ROW0_RESET >> 1, ROW1_RESET >> 1, ROW2_RESET >> 1, ROW3_RESET >> 1);
		send_point(point_t'{16'sd3, -16'sd3, 16'sd1, -16'sd1});
		send_point(point_t'{C_MAX, C_MIN, 16'sd5, -16'sd5});

		// All-zero matrix: everything collapses to zero without a clip.
		write_matrix('0, '0, '0, '0);
		send_point(point_t'{C_MAX, C_MIN, C_MAX, C_MIN});

		// Mixed signs in one row, against corner points.
		write_matrix({COEF_MAX, COEF_MIN, 16'sh1000, 16'shF000},
			{16'shFFFF, 16'sh0001, COEF_ZERO, COEF_MAX},
			ROW2_RESET, {COEF_MIN, COEF_ZERO, COEF_ZERO, COEF_MAX});
		send_point(point_t'{C_MAX, C_MIN, 16'sd2048, -16'sd2048});
		send_point(point_t'{C_MIN, C_MAX, -16'sd1, 16'sd1});

		// Random part: one matrix per phase, cycling through the mixes.
		phase = 0;
		while (random_sent < RANDOM_POINTS) begin
			mix = coef_mix_t'(phase % 4);
			write_matrix(random_row(mix), random_row(mix), random_row(mix),
				random_row(mix));
			batch = $urandom_range(80, 220);
			if (batch > RANDOM_POINTS - random_sent)
				batch = RANDOM_POINTS - random_sent;
			run_traffic(batch);
			phase++;
		end

		// Drain, then give stray beats time to show up.
		wait_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d points under %0d coefficient matrices;", sb.points_seen,
			settings_used);
		$display("%0d beats checked, %0d of them clipped, %0d mismatches.",
			sb.beats_checked, sb.clipped_beats, sb.mismatches);
		if (sb.mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+sv
sv/mpt_pkg.sv
sv/mpt_lane.sv
sv/mpt_merge.sv
sv/matrix4_point_transform_core.sv
test/matrix4_point_transform_core_test.sv
